[sv/bat_pkg.sv]
// ----------------------------------------------------------------------------
// Bank allocation table package
// Sizes, opcodes, type codes and register indexes shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package bat_pkg;

  localparam int BANK_COUNT = 256;
  localparam int APP_BANKS  = 24;
  localparam int BANK_W     = $clog2(BANK_COUNT);
  localparam int CNT_W      = BANK_W + 1;

  typedef enum logic [2:0] {
    OP_INIT       = 3'd0,
    OP_ALLOC      = 3'd1,
    OP_FREE       = 3'd2,
    OP_QUERY      = 3'd3,
    OP_COUNT_FREE = 3'd4,
    OP_COUNT_TYPE = 3'd5
  } op_t;

  localparam logic [7:0] TY_FREE     = 8'd0;
  localparam logic [7:0] TY_RESERVED = 8'd1;
  localparam logic [7:0] TY_APP      = 8'd2;
  localparam logic [7:0] TY_CACHE    = 8'd3;
  localparam logic [7:0] TY_DEBUG    = 8'd4;
  localparam logic [7:0] TY_SCRATCH  = 8'd5;
  localparam logic [7:0] NOT_FIXED   = 8'hFF;
  localparam logic [7:0] FAIL_BANK   = 8'hFF;
  localparam logic [7:0] COUNT_MAX   = 8'hFF;

  localparam logic [1:0] CFG_CACHE   = 2'd0;
  localparam logic [1:0] CFG_DEBUG   = 2'd1;
  localparam logic [1:0] CFG_SCRATCH = 2'd2;

  // Fixed system type of a bank, cache first, then debug, then scratch.
  function automatic logic [7:0] fixed_lookup(input logic [7:0] bank,
                                              input logic [7:0] cache,
                                              input logic [7:0] debug,
                                              input logic [7:0] scratch);
    logic [7:0] ty;
    ty = NOT_FIXED;
    if (bank == scratch) ty = TY_SCRATCH;
    if (bank == debug)   ty = TY_DEBUG;
    if (bank == cache)   ty = TY_CACHE;
    return ty;
  endfunction

  function automatic logic in_table(input logic [7:0] bank);
    return {1'b0, bank} < 9'(BANK_COUNT);
  endfunction

endpackage

`default_nettype wire

[sv/bank_allocation_table_top.sv]
// ----------------------------------------------------------------------------
// Bank allocation table
// Per-bank type table with init, first-fit alloc, free, query and counts.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | word
// in      | input     | in_valid / in_stall  | opcode, bank_index, type_code, slot_bitmap
// out     | output    | out_valid / out_stall| bank_result, alloc_failed, type_result,
//         |           |                      | count_result, slot_bitmap_out
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One table RAM port pair does all the work, one entry per cycle.
// First init clears all BANK_COUNT entries, then writes the APP_BANKS app entries and
// the 3 fixed banks; a later init skips the clear. Alloc scans up from bank APP_BANKS;
// counts scan every bank. One word in flight; the next is taken while a result waits.
// Table contents are undefined after reset until the first init sweeps them.
// ----------------------------------------------------------------------------
`default_nettype none

module bank_allocation_table_top
  import bat_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  opcode,
  input  wire logic [7:0]  bank_index,
  input  wire logic [7:0]  type_code,
  input  wire logic [23:0] slot_bitmap,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       bank_result,
  output logic             alloc_failed,
  output logic [7:0]       type_result,
  output logic [7:0]       count_result,
  output logic [23:0]      slot_bitmap_out,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_APP, S_FIX, S_SCAN, S_FREE, S_QUERY, S_DONE
  } state_t;

  state_t            state;
  logic              initialized;
  logic [23:0]       slot_bits;
  logic [7:0]        cache_bank;
  logic [7:0]        debug_bank;
  logic [7:0]        scratch_bank;
  logic [CNT_W-1:0]  cnt;
  logic [1:0]        fix_sel;
  logic              rd_pend;
  logic [BANK_W-1:0] rd_addr;
  logic              q_wait;

  op_t               op_q;
  logic [7:0]        bank_q;
  logic [7:0]        ty_q;

  logic [7:0]        res_bank;
  logic              res_fail;
  logic [7:0]        res_type;
  logic [7:0]        res_count;

  logic              ram_we;
  logic [BANK_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [BANK_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  logic [7:0]        fix_bank;
  logic [7:0]        fix_type;
  logic [7:0]        free_fixed;
  logic              alloc_hit;
  logic              app_bit;
  logic              out_free;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  assign free_fixed = fixed_lookup(bank_q, cache_bank, debug_bank, scratch_bank);
  assign alloc_hit  = rd_pend && (ram_rdata == TY_FREE) &&
                      (fixed_lookup(8'(rd_addr), cache_bank, debug_bank, scratch_bank)
                       == NOT_FIXED);
  assign app_bit    = 1'((slot_bits >> cnt));

  always_comb begin
    unique case (fix_sel)
      2'd0:    begin fix_bank = cache_bank;   fix_type = TY_CACHE;   end
      2'd1:    begin fix_bank = debug_bank;   fix_type = TY_DEBUG;   end
      default: begin fix_bank = scratch_bank; fix_type = TY_SCRATCH; end
    endcase
  end

  // Table port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = TY_FREE;
    ram_raddr = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[BANK_W-1:0];
      end
      S_APP: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[BANK_W-1:0];
        ram_wdata = app_bit ? TY_APP : TY_RESERVED;
      end
      S_FIX: begin
        ram_we    = in_table(fix_bank);
        ram_waddr = fix_bank[BANK_W-1:0];
        ram_wdata = fix_type;
      end
      S_SCAN: begin
        ram_raddr = cnt[BANK_W-1:0];
        if (op_q == OP_ALLOC && alloc_hit) begin
          ram_we    = 1'b1;
          ram_waddr = rd_addr;
          ram_wdata = ty_q;
        end
      end
      S_FREE: begin
        ram_we    = in_table(bank_q);
        ram_waddr = bank_q[BANK_W-1:0];
        if (free_fixed != NOT_FIXED) begin
          ram_wdata = free_fixed;
        end else if (bank_q < 8'(APP_BANKS)) begin
          ram_wdata = TY_RESERVED;
        end
      end
      S_QUERY: begin
        ram_raddr = bank_q[BANK_W-1:0];
      end
      default: ;
    endcase
  end

  bat_ram #(
    .WIDTH (8),
    .DEPTH (BANK_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      initialized  <= 1'b0;
      slot_bits    <= '0;
      cache_bank   <= 8'd255;
      debug_bank   <= 8'd254;
      scratch_bank <= 8'd253;
      cnt          <= '0;
      fix_sel      <= '0;
      rd_pend      <= 1'b0;
      q_wait       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CACHE:   cache_bank   <= cfg_data;
          CFG_DEBUG:   debug_bank   <= cfg_data;
          CFG_SCRATCH: scratch_bank <= cfg_data;
          default: ;
        endcase
      end

      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q      <= op_t'(opcode);
            bank_q    <= bank_index;
            ty_q      <= (opcode == OP_COUNT_FREE) ? TY_FREE : type_code;
            res_bank  <= (opcode == OP_ALLOC) ? FAIL_BANK : '0;
            res_fail  <= (opcode == OP_ALLOC);
            res_type  <= '0;
            res_count <= '0;
            cnt       <= (opcode == OP_ALLOC) ? CNT_W'(APP_BANKS) : '0;
            fix_sel   <= '0;
            q_wait    <= 1'b0;
            unique case (opcode)
              OP_INIT: begin
                slot_bits   <= slot_bitmap;
                initialized <= 1'b1;
                state       <= initialized ? S_APP : S_CLEAR;
              end
              OP_ALLOC:      state <= S_SCAN;
              OP_FREE:       state <= S_FREE;
              OP_QUERY:      state <= S_QUERY;
              OP_COUNT_FREE: state <= S_SCAN;
              OP_COUNT_TYPE: state <= S_SCAN;
              default:       state <= S_DONE;
            endcase
          end
        end

        S_CLEAR: begin
          if (cnt == CNT_W'(BANK_COUNT - 1)) begin
            cnt   <= '0;
            state <= S_APP;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end

        S_APP: begin
          if (cnt == CNT_W'(APP_BANKS - 1)) begin
            state <= S_FIX;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end

        S_FIX: begin
          if (fix_sel == 2'd2) begin
            state <= S_DONE;
          end else begin
            fix_sel <= fix_sel + 1'b1;
          end
        end

        S_SCAN: begin
          // issue one read a cycle, check the word that returns
          if (cnt < CNT_W'(BANK_COUNT)) begin
            cnt     <= cnt + 1'b1;
            rd_addr <= cnt[BANK_W-1:0];
          end
          rd_pend <= (cnt < CNT_W'(BANK_COUNT)) && !(op_q == OP_ALLOC && alloc_hit);
          if (op_q == OP_ALLOC) begin
            if (alloc_hit) begin
              res_bank <= 8'(rd_addr);
              res_fail <= 1'b0;
              state    <= S_DONE;
            end else if (!rd_pend && cnt == CNT_W'(BANK_COUNT)) begin
              state <= S_DONE;
            end
          end else begin
            if (rd_pend && ram_rdata == ty_q && res_count != COUNT_MAX) begin
              res_count <= res_count + 1'b1;
            end
            if (!rd_pend && cnt == CNT_W'(BANK_COUNT)) begin
              state <= S_DONE;
            end
          end
        end

        S_FREE: begin
          if (free_fixed == NOT_FIXED && bank_q < 8'(APP_BANKS)) begin
            slot_bits <= slot_bits & ~(24'd1 << bank_q);
          end
          state <= S_DONE;
        end

        S_QUERY: begin
          // present the address, then take the registered data once q_wait is set
          q_wait <= 1'b1;
          if (q_wait) begin
            res_type <= in_table(bank_q) ? ram_rdata : TY_FREE;
            state    <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            bank_result     <= res_bank;
            alloc_failed    <= res_fail;
            type_result     <= res_type;
            count_result    <= res_count;
            slot_bitmap_out <= slot_bits;
            state           <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/bat_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/bat_checker.sv]
// ----------------------------------------------------------------------------
// Bank allocation table checker
// Port-level properties of the block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bat_checker
  import bat_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [2:0]  opcode,
  input wire logic [7:0]  bank_index,
  input wire logic [7:0]  type_code,
  input wire logic [23:0] slot_bitmap,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  bank_result,
  input wire logic        alloc_failed,
  input wire logic [7:0]  type_result,
  input wire logic [7:0]  count_result,
  input wire logic [23:0] slot_bitmap_out,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [1:0]  cfg_index,
  input wire logic [7:0]  cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(bank_result) && $stable(count_result) &&
                               $stable(type_result) && $stable(slot_bitmap_out))
    else $error("stalled result word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken before the first finished");

  a_fail_bank: assert property (@(posedge clk) disable iff (rst)
    out_valid && alloc_failed |-> bank_result == FAIL_BANK && type_result == 8'd0 &&
                                  count_result == 8'd0)
    else $error("failed alloc with bad result fields");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && (type_result != 8'd0 || count_result != 8'd0) |->
      bank_result == 8'd0 && !alloc_failed)
    else $error("result word mixes alloc and query fields");

endmodule

bind bank_allocation_table_top bat_checker u_bat_checker (.*);

`default_nettype wire

[bench/bank_table_checker.sv]
// ----------------------------------------------------------------------------
// Bank allocation table checker
// Watches the config, operation and result channels. It keeps its own copy of
// the bank type table, slot bitmap and fixed bank selects, and predicts one
// reply per accepted operation word. Each accepted result word is compared
// field by field with the oldest predicted reply.
// ----------------------------------------------------------------------------
module bank_table_checker
  import bat_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [2:0]  opcode,
  input  wire logic [7:0]  bank_index,
  input  wire logic [7:0]  type_code,
  input  wire logic [23:0] slot_bitmap,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [7:0]  bank_result,
  input  wire logic        alloc_failed,
  input  wire logic [7:0]  type_result,
  input  wire logic [7:0]  count_result,
  input  wire logic [23:0] slot_bitmap_out,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  output int               errors,
  output int               pending,
  output int               full_allocs
);

  typedef struct packed {
    logic [7:0]  bank;
    logic        failed;
    logic [7:0]  ty;
    logic [7:0]  count;
    logic [23:0] slots;
  } reply_t;

  logic [7:0]  type_of_bank [BANK_COUNT];
  logic [23:0] slot_mask;
  logic        swept;
  logic [7:0]  cache_sel;
  logic [7:0]  debug_sel;
  logic [7:0]  scratch_sel;
  reply_t      reply_q [$];
  int          error_count = 0;
  int          miss_count = 0;

  assign errors      = error_count;
  assign full_allocs = miss_count;

  // Cache select wins over debug, debug over scratch.
  function automatic logic [7:0] fixed_kind(input logic [7:0] bank);
    if (bank == cache_sel) return TY_CACHE;
    if (bank == debug_sel) return TY_DEBUG;
    if (bank == scratch_sel) return TY_SCRATCH;
    return NOT_FIXED;
  endfunction

  function automatic logic [7:0] tally_type(input logic [7:0] ty);
    logic [7:0] n;
    int i;
    n = '0;
    for (i = 0; i < BANK_COUNT; i++) begin
      if (type_of_bank[i] == ty && n < COUNT_MAX) n++;
    end
    return n;
  endfunction

  function automatic reply_t apply_bank_op(input logic [2:0] op, input logic [7:0] bank,
                                           input logic [7:0] ty, input logic [23:0] slots);
    reply_t r;
    logic [7:0] kind;
    int i;
    r = '0;
    case (op)
      OP_INIT: begin
        if (!swept) begin
          for (i = 0; i < BANK_COUNT; i++) type_of_bank[i] = TY_FREE;
          swept = 1'b1;
        end
        slot_mask = slots;
        for (i = 0; i < APP_BANKS; i++) type_of_bank[i] = slots[i] ? TY_APP : TY_RESERVED;
        // system banks go last, so scratch lands on top when selects collide
        type_of_bank[cache_sel]   = TY_CACHE;
        type_of_bank[debug_sel]   = TY_DEBUG;
        type_of_bank[scratch_sel] = TY_SCRATCH;
      end
      OP_ALLOC: begin
        r.bank   = FAIL_BANK;
        r.failed = 1'b1;
        for (i = APP_BANKS; i < BANK_COUNT; i++) begin
          if (fixed_kind(8'(i)) == NOT_FIXED && type_of_bank[i] == TY_FREE) begin
            type_of_bank[i] = ty;
            r.bank   = 8'(i);
            r.failed = 1'b0;
            break;
          end
        end
      end
      OP_FREE: begin
        kind = fixed_kind(bank);
        if (kind != NOT_FIXED) begin
          type_of_bank[bank] = kind;
        end else if (bank < APP_BANKS) begin
          type_of_bank[bank] = TY_RESERVED;
          slot_mask[bank]    = 1'b0;
        end else begin
          type_of_bank[bank] = TY_FREE;
        end
      end
      OP_QUERY:      r.ty = type_of_bank[bank];
      OP_COUNT_FREE: r.count = tally_type(TY_FREE);
      OP_COUNT_TYPE: r.count = tally_type(ty);
      default: ;
    endcase
    r.slots = slot_mask;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    reply_t want;
    int i;
    if (rst) begin
      for (i = 0; i < BANK_COUNT; i++) type_of_bank[i] = TY_FREE;
      slot_mask   = '0;
      swept       = 1'b0;
      cache_sel   = 8'd255;
      debug_sel   = 8'd254;
      scratch_sel = 8'd253;
      reply_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CACHE:   cache_sel = cfg_data;
          CFG_DEBUG:   debug_sel = cfg_data;
          CFG_SCRATCH: scratch_sel = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $error("result word with no operation outstanding");
          error_count++;
        end else begin
          want = reply_q.pop_front();
          check_field("bank_result", want.bank, bank_result);
          check_field("alloc_failed", want.failed, alloc_failed);
          check_field("type_result", want.ty, type_result);
          check_field("count_result", want.count, count_result);
          check_field("slot_bitmap_out", want.slots, slot_bitmap_out);
          if (want.failed) miss_count++;
        end
      end
      if (in_valid && !in_stall) begin
        reply_q.push_back(apply_bank_op(opcode, bank_index, type_code, slot_bitmap));
      end
    end
    pending <= reply_q.size();
  end

endmodule

[bench/bank_allocation_table_top_tb.sv]
// ----------------------------------------------------------------------------
// Bank allocation table testbench
// Drives config writes and operation words into the bank allocation table and
// lets the checker predict and compare every result word. Directed passes cover
// the corner cases and a full fill of the dynamic pool, then random phases run
// under several fixed bank settings and idle patterns.
// ----------------------------------------------------------------------------
module bank_allocation_table_top_tb;
  import bat_pkg::*;

  localparam int          PHASE_ITEMS = 254;
  localparam int          STALL_LIMIT = 6000;
  localparam int          TAIL_CYCLES = 300;
  localparam logic [2:0]  OP_SPARE6   = 3'd6;
  localparam logic [2:0]  OP_SPARE7   = 3'd7;
  localparam logic [23:0] ALL_SLOTS   = 24'hFFFFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [2:0]  opcode = OP_INIT;
  logic [7:0]  bank_index = '0;
  logic [7:0]  type_code = '0;
  logic [23:0] slot_bitmap = '0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = CFG_CACHE;
  logic [7:0]  cfg_data = '0;

  logic        in_stall;
  logic        out_valid;
  logic [7:0]  bank_result;
  logic        alloc_failed;
  logic [7:0]  type_result;
  logic [7:0]  count_result;
  logic [23:0] slot_bitmap_out;
  logic        cfg_ready;

  int          error_count;
  int          pending;
  int          full_pool_allocs;
  int          tx_pct = 0;
  int          rx_pct = 0;
  int          quiet_cycles = 0;
  int          total_items = 0;
  int          settings_used = 0;
  int          op_seen [8] = '{default: 0};
  logic [7:0]  fixed_banks [3] = '{8'd255, 8'd254, 8'd253};

  bank_allocation_table_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .bank_index(bank_index), .type_code(type_code),
    .slot_bitmap(slot_bitmap),
    .out_valid(out_valid), .out_stall(out_stall),
    .bank_result(bank_result), .alloc_failed(alloc_failed), .type_result(type_result),
    .count_result(count_result), .slot_bitmap_out(slot_bitmap_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bank_table_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .bank_index(bank_index), .type_code(type_code),
    .slot_bitmap(slot_bitmap),
    .out_valid(out_valid), .out_stall(out_stall),
    .bank_result(bank_result), .alloc_failed(alloc_failed), .type_result(type_result),
    .count_result(count_result), .slot_bitmap_out(slot_bitmap_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(error_count), .pending(pending), .full_allocs(full_pool_allocs)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("bank_allocation_table_top_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      1:       begin tx_pct = 68; rx_pct = 0;  end
      2:       begin tx_pct = 0;  rx_pct = 68; end
      3:       begin tx_pct = 17; rx_pct = 17; end
      default: begin tx_pct = 0;  rx_pct = 0;  end
    endcase
  endtask

  // Hold valid across back-to-back words; drop it only for an idle gap.
  task automatic send_item(input logic [2:0] op, input logic [7:0] bank,
                           input logic [7:0] ty, input logic [23:0] slots);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    bank_index  <= bank;
    type_code   <= ty;
    slot_bitmap <= slots;
    do @(posedge clk); while (in_stall);
    op_seen[op]++;
    total_items++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_fixed_banks(input logic [7:0] c, input logic [7:0] d,
                                 input logic [7:0] s);
    write_reg(CFG_CACHE, c);
    write_reg(CFG_DEBUG, d);
    write_reg(CFG_SCRATCH, s);
    cfg_valid <= 1'b0;
    fixed_banks = '{c, d, s};
    settings_used++;
  endtask

  // Favor app banks, system banks and the low end of the dynamic pool.
  function automatic logic [7:0] pick_bank();
    int sel;
    sel = $urandom_range(99);
    if (sel < 25) return 8'($urandom_range(APP_BANKS - 1));
    if (sel < 40) return fixed_banks[$urandom_range(2)];
    if (sel < 80) return 8'($urandom_range(APP_BANKS + 63, APP_BANKS));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_type();
    if ($urandom_range(1) == 0) return 8'($urandom_range(7));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [23:0] pick_bitmap();
    int sel;
    sel = $urandom_range(9);
    if (sel < 2) return '0;
    if (sel < 4) return ALL_SLOTS;
    return 24'($urandom);
  endfunction

  task automatic run_phase(input int quota);
    int sent;
    int sel;
    int burst;
    send_item(OP_INIT, pick_bank(), pick_type(), pick_bitmap());
    sent = 1;
    while (sent < quota) begin
      sel = $urandom_range(99);
      if (sel < 30) begin
        send_item(OP_ALLOC, 8'($urandom), pick_type(), 24'($urandom));
        sent++;
      end else if (sel < 50) begin
        send_item(OP_FREE, pick_bank(), pick_type(), 24'($urandom));
        sent++;
      end else if (sel < 65) begin
        send_item(OP_QUERY, pick_bank(), pick_type(), 24'($urandom));
        sent++;
      end else if (sel < 73) begin
        send_item(OP_COUNT_FREE, 8'($urandom), pick_type(), 24'($urandom));
        sent++;
      end else if (sel < 83) begin
        send_item(OP_COUNT_TYPE, 8'($urandom),
                  ($urandom_range(9) < 7) ? 8'($urandom_range(5)) : 8'($urandom),
                  24'($urandom));
        sent++;
      end else if (sel < 88) begin
        send_item(OP_INIT, pick_bank(), pick_type(), pick_bitmap());
        sent++;
      end else if (sel < 90) begin
        send_item($urandom_range(1) ? OP_SPARE6 : OP_SPARE7, 8'($urandom), 8'($urandom),
                  24'($urandom));
        sent++;
      end else if (sel < 92) begin
        drain_results();
      end else begin
        // run of allocs to push the pool toward full
        burst = $urandom_range(40, 10);
        repeat (burst) send_item(OP_ALLOC, 8'($urandom), pick_type(), 24'($urandom));
        sent += burst;
      end
    end
  endtask

  initial begin
    int p;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Cache sits on an app bank; debug and scratch share one bank.
    set_fixed_banks(8'd0, 8'd40, 8'd40);
    set_idling(0);
    send_item(OP_SPARE7, 8'hFF, 8'hFF, ALL_SLOTS);
    send_item(OP_FREE, 8'd30, 8'd0, 24'd0);
    send_item(OP_INIT, 8'd0, 8'd0, ALL_SLOTS);
    send_item(OP_QUERY, 8'd0, 8'd0, 24'd0);
    send_item(OP_QUERY, 8'd40, 8'd0, 24'd0);
    send_item(OP_QUERY, 8'd23, 8'd0, 24'd0);
    send_item(OP_QUERY, 8'd30, 8'd0, 24'd0);
    send_item(OP_COUNT_FREE, 8'd0, 8'd0, 24'd0);
    // a free type code leaves the bank in the pool
    send_item(OP_ALLOC, 8'd0, TY_FREE, 24'd0);
    send_item(OP_ALLOC, 8'd0, 8'hFF, 24'd0);
    send_item(OP_ALLOC, 8'd0, 8'd7, 24'd0);
    send_item(OP_COUNT_TYPE, 8'd0, 8'hFF, 24'd0);
    send_item(OP_FREE, 8'd40, 8'd0, 24'd0);
    send_item(OP_QUERY, 8'd40, 8'd0, 24'd0);
    send_item(OP_FREE, 8'd0, 8'd0, 24'd0);
    send_item(OP_FREE, 8'd5, 8'd0, 24'd0);
    send_item(OP_FREE, 8'd24, 8'd0, 24'd0);
    send_item(OP_FREE, 8'd255, 8'd0, 24'd0);
    send_item(OP_QUERY, 8'd255, 8'd0, 24'd0);
    // later init must leave dynamic banks alone
    send_item(OP_INIT, 8'd0, 8'd0, 24'd0);
    send_item(OP_QUERY, 8'd25, 8'd0, 24'd0);
    send_item(OP_COUNT_TYPE, 8'd0, TY_RESERVED, 24'd0);
    send_item(OP_SPARE6, 8'h5A, 8'hA5, 24'h5A5A5A);
    send_item(OP_QUERY, 8'd0, 8'd0, 24'd0);
    send_item(OP_COUNT_FREE, 8'd0, 8'd0, 24'd0);
    drain_results();

    // All selects on bank 0: return the banks still in use, then fill every
    // dynamic bank as reserved so the reserved count reaches its ceiling.
    set_fixed_banks(8'd0, 8'd0, 8'd0);
    set_idling(1);
    send_item(OP_FREE, 8'd25, 8'($urandom), 24'($urandom));
    send_item(OP_FREE, 8'd40, 8'($urandom), 24'($urandom));
    send_item(OP_INIT, 8'($urandom), 8'($urandom), 24'd0);
    repeat (BANK_COUNT - APP_BANKS + 3) begin
      send_item(OP_ALLOC, 8'($urandom), TY_RESERVED, 24'($urandom));
    end
    send_item(OP_COUNT_TYPE, 8'($urandom), TY_RESERVED, 24'($urandom));
    drain_results();

    // Bank 0 is no longer a fixed bank and frees as reserved; one more reserved bank saturates.
    set_fixed_banks(8'd255, 8'd254, 8'd253);
    set_idling(2);
    send_item(OP_FREE, 8'd0, 8'($urandom), 24'($urandom));
    send_item(OP_COUNT_TYPE, 8'($urandom), TY_RESERVED, 24'($urandom));
    run_phase(2 * PHASE_ITEMS - 240);

    for (p = 0; p < 4; p++) begin
      drain_results();
      case (p)
        0:       set_fixed_banks(8'd24, 8'd25, 8'd26);
        2:       set_fixed_banks(8'($urandom_range(40, 20)), 8'($urandom_range(40, 20)),
                                 8'($urandom_range(40, 20)));
        default: set_fixed_banks(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      set_idling((p + 3) % 4);
      run_phase(PHASE_ITEMS);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("summary: %0d operations (init %0d, alloc %0d, free %0d, query %0d,",
             total_items, op_seen[OP_INIT], op_seen[OP_ALLOC], op_seen[OP_FREE],
             op_seen[OP_QUERY]);
    $display("summary: counts %0d, unused opcodes %0d) over %0d bank settings, %0d full-pool allocs",
             op_seen[OP_COUNT_FREE] + op_seen[OP_COUNT_TYPE],
             op_seen[OP_SPARE6] + op_seen[OP_SPARE7], settings_used, full_pool_allocs);
    if (error_count == 0) begin
      $display("bank_allocation_table_top_tb: PASS");
    end else begin
      $display("bank_allocation_table_top_tb: FAIL");
    end
    $finish;
  end

endmodule
